### rtl/core/dcs_pkg.sv
// Package: request/result types and constants for the DMA channel sequencer.
`default_nettype none
package dcs_pkg;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;
  localparam logic [1:0] MODE_REPLY = 2'd3;

  localparam logic [1:0] KIND_RDATA = 2'd0;
  localparam logic [1:0] KIND_XFER  = 2'd1;
  localparam logic [1:0] KIND_FETCH = 2'd2;
  localparam logic [1:0] KIND_IRQ   = 2'd3;

  localparam logic [4:0] R_STATUS = 5'h00;
  localparam logic [4:0] R_DOCTL  = 5'h02;
  localparam logic [4:0] R_SCCTL  = 5'h03;
  localparam logic [4:0] R_MTC    = 5'h05;
  localparam logic [4:0] R_MARH   = 5'h06;
  localparam logic [4:0] R_MARL   = 5'h07;
  localparam logic [4:0] R_DARH   = 5'h0a;
  localparam logic [4:0] R_DARL   = 5'h0b;
  localparam logic [4:0] R_BTC    = 5'h0d;
  localparam logic [4:0] R_BARH   = 5'h0e;
  localparam logic [4:0] R_BARL   = 5'h0f;
  localparam logic [4:0] R_NIV    = 5'h12;
  localparam logic [4:0] R_EIV    = 5'h13;
  localparam logic [4:0] R_MFC    = 5'h14;
  localparam logic [4:0] R_CPR    = 5'h16;
  localparam logic [4:0] R_DFC    = 5'h18;
  localparam logic [4:0] R_BFC    = 5'h1c;
  localparam logic [4:0] R_GCR    = 5'h1f;

  localparam logic [7:0] VEC_DONE  = 8'h6a;
  localparam logic [7:0] VEC_ERROR = 8'h6b;
  localparam logic [2:0] IRQ_LEVEL = 3'd3;
  localparam logic [7:0] ST_ACTIVE = 8'h08;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  channel;
    logic [4:0]  reg_index;
    logic [15:0] write_data;
    logic        upper_enable;
    logic        lower_enable;
    logic [31:0] desc_address;
    logic [15:0] desc_count;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  out_channel;
    logic [15:0] read_data;
    logic [23:0] src_address;
    logic [23:0] dst_address;
    logic [2:0]  size_bytes;
    logic [31:0] fetch_address;
    logic [7:0]  irq_vector;
    logic [2:0]  irq_level;
    logic        last;
  } res_t;

  // one channel's full register context, one memory word
  typedef struct packed {
    logic [7:0]  status;
    logic [7:0]  error;
    logic [7:0]  dev_ctl;
    logic [7:0]  op_ctl;
    logic [7:0]  seq_ctl;
    logic [7:0]  chan_ctl;
    logic [15:0] mem_count;
    logic [31:0] mem_addr;
    logic [31:0] dev_addr;
    logic [15:0] block_count;
    logic [31:0] base_addr;
    logic [7:0]  normal_vec;
    logic [7:0]  error_vec;
    logic [31:0] fcpg;
    logic [7:0]  gen_ctl;
    logic        pend;
  } ctx_t;

  localparam int CTX_W = $bits(ctx_t);

endpackage
`default_nettype wire

### rtl/core/dcs_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module dcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/core/dma_channel_sequencer_core.sv
// Top level: DMA channel register file and transfer sequencer.
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_stall  | dcs_pkg::req_t
// out_    | out | out_valid/out_stall| dcs_pkg::res_t
// A request passes through context read from the channel memory (registered
// read), modify, and write back with up to two results, then result delivery.
// A one-shot clearing pass over all CHANNELS contexts runs after reset before any
// request is accepted. Output stalls hold the sequencer in its emit state.
`default_nettype none
module dma_channel_sequencer_core #(
  parameter int CHANNELS = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire dcs_pkg::req_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output dcs_pkg::res_t        out_data
);
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RD = 1 << AW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_OUT0 = 3'd4;
  localparam logic [2:0] S_OUT1 = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [AW:0]       clr_r, clr_nxt;
  dcs_pkg::req_t     req_r;
  dcs_pkg::res_t     res0_r, res1_r, res0_nxt, res1_nxt;
  logic [1:0]        nres_r, nres_nxt;
  logic              we;
  logic [AW-1:0]     waddr, raddr;
  dcs_pkg::ctx_t     wctx, rctx, c;
  logic [dcs_pkg::CTX_W-1:0] rdata;

  dcs_ram #(.WIDTH(dcs_pkg::CTX_W), .DEPTH(RD)) u_ctx (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wctx), .raddr(raddr), .rdata(rdata)
  );
  assign rctx = dcs_pkg::ctx_t'(rdata);
  assign raddr = req_r.channel[AW-1:0];

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT0) || (state_r == S_OUT1);
  assign out_data = (state_r == S_OUT1) ? res1_r : res0_r;

  // modify logic
  dcs_pkg::res_t r [2];
  logic [1:0]    n;
  logic [2:0]    sz;
  logic [15:0]   d;
  logic [7:0]    b;

  function automatic dcs_pkg::res_t mk(logic [1:0] k, logic [1:0] ch);
    dcs_pkg::res_t x;
    x = '0;
    x.kind = k;
    x.out_channel = ch;
    return x;
  endfunction

  always_comb begin
    c = rctx;
    n = 2'd0;
    r[0] = '0;
    r[1] = '0;
    d = req_r.write_data;
    b = d[7:0];
    sz = 3'd1;
    unique case (req_r.mode)
      dcs_pkg::MODE_WRITE: begin
        case (req_r.reg_index)
          dcs_pkg::R_STATUS: if (req_r.upper_enable) begin
            c.status = c.status & ~(d[15:8] & 8'hf6);
            if (d[12]) c.error = 8'h00;
          end
          dcs_pkg::R_DOCTL: begin
            if (req_r.upper_enable) c.dev_ctl = d[15:8];
            if (req_r.lower_enable) c.op_ctl = b;
          end
          dcs_pkg::R_SCCTL: begin
            if (req_r.upper_enable) c.seq_ctl = d[15:8];
            if (req_r.lower_enable) begin
              c.chan_ctl = b;
              if (b[7]) begin
                c.status = (c.status & 8'h0f) | dcs_pkg::ST_ACTIVE;
                if ((c.op_ctl & 8'h0c) != 8'h00) begin
                  r[0] = mk(dcs_pkg::KIND_FETCH, req_r.channel);
                  r[0].fetch_address = c.base_addr;
                  n = 2'd1;
                  c.pend = 1'b1;
                  if (c.block_count != 16'd0) c.block_count = c.block_count - 16'd1;
                end
              end
              if (b[4] && (c.status & dcs_pkg::ST_ACTIVE) != 8'h00) begin
                c.status = (c.status | 8'h90) & ~dcs_pkg::ST_ACTIVE;
                c.error = 8'h11;
                c.chan_ctl = c.chan_ctl & 8'h3f;
                c.pend = 1'b0;
                r[n[0]] = mk(dcs_pkg::KIND_IRQ, req_r.channel);
                r[n[0]].irq_vector = dcs_pkg::VEC_ERROR;
                r[n[0]].irq_level = dcs_pkg::IRQ_LEVEL;
                n = n + 2'd1;
              end
            end
          end
          dcs_pkg::R_MTC:  c.mem_count = d;
          dcs_pkg::R_MARH: c.mem_addr[31:16] = d;
          dcs_pkg::R_MARL: c.mem_addr[15:0] = d;
          dcs_pkg::R_DARH: c.dev_addr[31:16] = d;
          dcs_pkg::R_DARL: c.dev_addr[15:0] = d;
          dcs_pkg::R_BTC:  c.block_count = d;
          dcs_pkg::R_BARH: c.base_addr[31:16] = d;
          dcs_pkg::R_BARL: c.base_addr[15:0] = d;
          dcs_pkg::R_NIV:  c.normal_vec = b;
          dcs_pkg::R_EIV:  c.error_vec = b;
          dcs_pkg::R_MFC:  c.fcpg[7:0] = b;
          dcs_pkg::R_CPR:  c.fcpg[15:8] = b;
          dcs_pkg::R_DFC:  c.fcpg[23:16] = b;
          dcs_pkg::R_BFC:  c.fcpg[31:24] = b;
          dcs_pkg::R_GCR:  c.gen_ctl = b;
          default: ;
        endcase
      end
      dcs_pkg::MODE_READ: begin
        r[0] = mk(dcs_pkg::KIND_RDATA, req_r.channel);
        n = 2'd1;
        case (req_r.reg_index)
          dcs_pkg::R_STATUS: r[0].read_data = {c.status, c.error};
          dcs_pkg::R_DOCTL:  r[0].read_data = {c.dev_ctl, c.op_ctl};
          dcs_pkg::R_SCCTL:  r[0].read_data = {c.seq_ctl, c.chan_ctl};
          dcs_pkg::R_MTC:    r[0].read_data = c.mem_count;
          dcs_pkg::R_MARH:   r[0].read_data = c.mem_addr[31:16];
          dcs_pkg::R_MARL:   r[0].read_data = c.mem_addr[15:0];
          dcs_pkg::R_DARH:   r[0].read_data = c.dev_addr[31:16];
          dcs_pkg::R_DARL:   r[0].read_data = c.dev_addr[15:0];
          dcs_pkg::R_BTC:    r[0].read_data = c.block_count;
          dcs_pkg::R_BARH:   r[0].read_data = c.base_addr[31:16];
          dcs_pkg::R_BARL:   r[0].read_data = c.base_addr[15:0];
          dcs_pkg::R_NIV:    r[0].read_data = {8'h00, c.normal_vec};
          dcs_pkg::R_EIV:    r[0].read_data = {8'h00, c.error_vec};
          dcs_pkg::R_MFC:    r[0].read_data = {8'h00, c.fcpg[7:0]};
          dcs_pkg::R_CPR:    r[0].read_data = {8'h00, c.fcpg[15:8]};
          dcs_pkg::R_DFC:    r[0].read_data = {8'h00, c.fcpg[23:16]};
          dcs_pkg::R_BFC:    r[0].read_data = {8'h00, c.fcpg[31:24]};
          dcs_pkg::R_GCR:    r[0].read_data = {8'h00, c.gen_ctl};
          default:           r[0].read_data = 16'h00ff;
        endcase
      end
      dcs_pkg::MODE_TICK: begin
        if ((c.status & dcs_pkg::ST_ACTIVE) != 8'h00 && !c.pend) begin
          case (c.op_ctl[5:4])
            2'b01:   sz = 3'd2;
            2'b10:   sz = 3'd4;
            default: sz = 3'd1;
          endcase
          r[0] = mk(dcs_pkg::KIND_XFER, req_r.channel);
          r[0].size_bytes = sz;
          if (c.op_ctl[7]) begin
            r[0].src_address = c.dev_addr[23:0];
            r[0].dst_address = c.mem_addr[23:0];
          end else begin
            r[0].src_address = c.mem_addr[23:0];
            r[0].dst_address = c.dev_addr[23:0];
          end
          n = 2'd1;
          if (c.mem_count != 16'd0) c.mem_count = c.mem_count - 16'd1;
          if (c.seq_ctl[1:0] == 2'b01) c.dev_addr = c.dev_addr + {29'd0, sz};
          else if (c.seq_ctl[1:0] == 2'b10) c.dev_addr = c.dev_addr - {29'd0, sz};
          if (c.seq_ctl[3:2] == 2'b01) c.mem_addr = c.mem_addr + {29'd0, sz};
          else if (c.seq_ctl[3:2] == 2'b10) c.mem_addr = c.mem_addr - {29'd0, sz};
          if (c.mem_count == 16'd0) begin
            if ((c.op_ctl & 8'h0c) != 8'h00 && c.block_count != 16'd0) begin
              c.block_count = c.block_count - 16'd1;
              c.base_addr = c.base_addr + 32'd6;
              r[1] = mk(dcs_pkg::KIND_FETCH, req_r.channel);
              r[1].fetch_address = c.base_addr;
              c.pend = 1'b1;
            end else begin
              c.status = (c.status | 8'he0) & ~dcs_pkg::ST_ACTIVE;
              c.chan_ctl = c.chan_ctl & 8'h3f;
              r[1] = mk(dcs_pkg::KIND_IRQ, req_r.channel);
              r[1].irq_vector = dcs_pkg::VEC_DONE;
              r[1].irq_level = dcs_pkg::IRQ_LEVEL;
            end
            n = 2'd2;
          end
        end
      end
      dcs_pkg::MODE_REPLY: begin
        if (c.pend) begin
          c.mem_addr = req_r.desc_address;
          c.mem_count = req_r.desc_count;
          c.pend = 1'b0;
        end
      end
      default: ;
    endcase
    if (n == 2'd1) r[0].last = 1'b1;
    if (n == 2'd2) r[1].last = 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    res0_nxt = res0_r;
    res1_nxt = res1_r;
    nres_nxt = nres_r;
    we = 1'b0;
    waddr = req_r.channel[AW-1:0];
    wctx = c;
    unique case (state_r)
      S_CLR: begin
        we = 1'b1;
        waddr = clr_r[AW-1:0];
        wctx = '0;
        wctx.normal_vec = 8'h0f;
        wctx.error_vec = 8'h0f;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (AW+1)'(CHANNELS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (in_valid) begin
        if ({1'b0, in_data.channel} < 3'(CHANNELS)) state_nxt = S_RD;
      end
      S_RD: state_nxt = S_MOD;
      S_MOD: begin
        we = 1'b1;
        res0_nxt = r[0];
        res1_nxt = r[1];
        nres_nxt = n;
        state_nxt = (n == 2'd0) ? S_IDLE : S_OUT0;
      end
      S_OUT0: if (!out_stall) state_nxt = (nres_r == 2'd2) ? S_OUT1 : S_IDLE;
      S_OUT1: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r <= '0;
      nres_r <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      nres_r <= nres_nxt;
    end
    if (state_r == S_IDLE && in_valid) req_r <= in_data;
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

`ifndef SYNTH
  a_last_single: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT0 && nres_r == 2'd1) |-> out_data.last)
    else $error("single result missing last");
  a_first_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT0 && nres_r == 2'd2) |-> !out_data.last)
    else $error("first of two results marked last");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted while results pending");
`endif
endmodule
`default_nettype wire

### tb/dma_channel_sequencer_core_tb.sv
// Testbench: directed and randomized request traffic with a predictor and in-order result checking.
`default_nettype none
module dma_channel_sequencer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  dcs_pkg::req_t in_data;
  dcs_pkg::res_t out_data;

  dma_channel_sequencer_core dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  // predictor state
  logic [7:0]  m_status [4], m_error [4], m_devc [4], m_opc [4], m_seqc [4], m_chc [4];
  logic [15:0] m_mtc [4], m_btc [4];
  logic [31:0] m_mar [4], m_dar [4], m_bar [4], m_fcpg [4];
  logic [7:0]  m_niv [4], m_eiv [4], m_gcr [4];
  logic        m_pend [4];

  dcs_pkg::req_t pending_reqs[$];
  dcs_pkg::res_t expected_results[$];
  dcs_pkg::res_t step_out[$];
  int   mismatches = 0;
  int   sender_idle = 0, receiver_idle = 0;
  bit   hold_off = 0;

  task automatic report(input string what, input dcs_pkg::res_t got,
                        input dcs_pkg::res_t exp);
    $display("MISMATCH %s: got %h expected %h", what, got, exp);
    mismatches++;
  endtask

  function automatic dcs_pkg::res_t blank(input logic [1:0] k, input logic [1:0] ch);
    dcs_pkg::res_t r;
    r = '0;
    r.kind = k;
    r.out_channel = ch;
    return r;
  endfunction

  task automatic push_fetch(input int ch);
    dcs_pkg::res_t r;
    r = blank(dcs_pkg::KIND_FETCH, ch[1:0]);
    r.fetch_address = m_bar[ch];
    m_pend[ch] = 1;
    step_out.push_back(r);
  endtask

  task automatic push_irq(input int ch, input logic [7:0] v);
    dcs_pkg::res_t r;
    r = blank(dcs_pkg::KIND_IRQ, ch[1:0]);
    r.irq_vector = v;
    r.irq_level = dcs_pkg::IRQ_LEVEL;
    step_out.push_back(r);
  endtask

  function automatic logic [15:0] read_reg(input int ch, input logic [4:0] idx);
    case (idx)
      dcs_pkg::R_STATUS: return {m_status[ch], m_error[ch]};
      dcs_pkg::R_DOCTL:  return {m_devc[ch], m_opc[ch]};
      dcs_pkg::R_SCCTL:  return {m_seqc[ch], m_chc[ch]};
      dcs_pkg::R_MTC:    return m_mtc[ch];
      dcs_pkg::R_MARH:   return m_mar[ch][31:16];
      dcs_pkg::R_MARL:   return m_mar[ch][15:0];
      dcs_pkg::R_DARH:   return m_dar[ch][31:16];
      dcs_pkg::R_DARL:   return m_dar[ch][15:0];
      dcs_pkg::R_BTC:    return m_btc[ch];
      dcs_pkg::R_BARH:   return m_bar[ch][31:16];
      dcs_pkg::R_BARL:   return m_bar[ch][15:0];
      dcs_pkg::R_NIV:    return {8'h0, m_niv[ch]};
      dcs_pkg::R_EIV:    return {8'h0, m_eiv[ch]};
      dcs_pkg::R_MFC:    return {8'h0, m_fcpg[ch][7:0]};
      dcs_pkg::R_CPR:    return {8'h0, m_fcpg[ch][15:8]};
      dcs_pkg::R_DFC:    return {8'h0, m_fcpg[ch][23:16]};
      dcs_pkg::R_BFC:    return {8'h0, m_fcpg[ch][31:24]};
      dcs_pkg::R_GCR:    return {8'h0, m_gcr[ch]};
      default:           return 16'h00ff;
    endcase
  endfunction

  task automatic predict_request(input dcs_pkg::req_t q);
    int ch;
    logic [15:0] d;
    logic [7:0] b;
    logic [31:0] sz;
    dcs_pkg::res_t r;
    ch = q.channel;
    d = q.write_data;
    b = d[7:0];
    step_out.delete();
    case (q.mode)
      dcs_pkg::MODE_WRITE: begin
        case (q.reg_index)
          dcs_pkg::R_STATUS: if (q.upper_enable) begin
            m_status[ch] &= ~(d[15:8] & 8'hf6);
            if (d[12]) m_error[ch] = 0;
          end
          dcs_pkg::R_DOCTL: begin
            if (q.upper_enable) m_devc[ch] = d[15:8];
            if (q.lower_enable) m_opc[ch] = b;
          end
          dcs_pkg::R_SCCTL: begin
            if (q.upper_enable) m_seqc[ch] = d[15:8];
            if (q.lower_enable) begin
              m_chc[ch] = b;
              if (b[7]) begin
                m_status[ch] = (m_status[ch] & 8'h0f) | dcs_pkg::ST_ACTIVE;
                if (m_opc[ch] & 8'h0c) begin
                  push_fetch(ch);
                  if (m_btc[ch] > 0) m_btc[ch]--;
                end
              end
              if (b[4] && (m_status[ch] & dcs_pkg::ST_ACTIVE)) begin
                m_status[ch] = (m_status[ch] | 8'h90) & ~dcs_pkg::ST_ACTIVE;
                m_error[ch] = 8'h11;
                m_chc[ch] &= 8'h3f;
                m_pend[ch] = 0;
                push_irq(ch, dcs_pkg::VEC_ERROR);
              end
            end
          end
          dcs_pkg::R_MTC:  m_mtc[ch] = d;
          dcs_pkg::R_MARH: m_mar[ch][31:16] = d;
          dcs_pkg::R_MARL: m_mar[ch][15:0] = d;
          dcs_pkg::R_DARH: m_dar[ch][31:16] = d;
          dcs_pkg::R_DARL: m_dar[ch][15:0] = d;
          dcs_pkg::R_BTC:  m_btc[ch] = d;
          dcs_pkg::R_BARH: m_bar[ch][31:16] = d;
          dcs_pkg::R_BARL: m_bar[ch][15:0] = d;
          dcs_pkg::R_NIV:  m_niv[ch] = b;
          dcs_pkg::R_EIV:  m_eiv[ch] = b;
          dcs_pkg::R_MFC:  m_fcpg[ch][7:0] = b;
          dcs_pkg::R_CPR:  m_fcpg[ch][15:8] = b;
          dcs_pkg::R_DFC:  m_fcpg[ch][23:16] = b;
          dcs_pkg::R_BFC:  m_fcpg[ch][31:24] = b;
          dcs_pkg::R_GCR:  m_gcr[ch] = b;
          default: ;
        endcase
      end
      dcs_pkg::MODE_READ: begin
        r = blank(dcs_pkg::KIND_RDATA, ch[1:0]);
        r.read_data = read_reg(ch, q.reg_index);
        step_out.push_back(r);
      end
      dcs_pkg::MODE_TICK: if ((m_status[ch] & dcs_pkg::ST_ACTIVE) && !m_pend[ch]) begin
        case (m_opc[ch] & 8'h30)
          8'h10: sz = 2;
          8'h20: sz = 4;
          default: sz = 1;
        endcase
        r = blank(dcs_pkg::KIND_XFER, ch[1:0]);
        if (m_opc[ch][7]) begin
          r.src_address = m_dar[ch][23:0];
          r.dst_address = m_mar[ch][23:0];
        end else begin
          r.src_address = m_mar[ch][23:0];
          r.dst_address = m_dar[ch][23:0];
        end
        r.size_bytes = sz[2:0];
        step_out.push_back(r);
        if (m_mtc[ch] > 0) m_mtc[ch]--;
        case (m_seqc[ch][1:0])
          2'b01: m_dar[ch] += sz;
          2'b10: m_dar[ch] -= sz;
          default: ;
        endcase
        case (m_seqc[ch][3:2])
          2'b01: m_mar[ch] += sz;
          2'b10: m_mar[ch] -= sz;
          default: ;
        endcase
        if (m_mtc[ch] == 0) begin
          if ((m_opc[ch] & 8'h0c) && m_btc[ch] > 0) begin
            m_btc[ch]--;
            m_bar[ch] += 6;
            push_fetch(ch);
          end else begin
            m_status[ch] = (m_status[ch] | 8'he0) & ~dcs_pkg::ST_ACTIVE;
            m_chc[ch] &= 8'h3f;
            push_irq(ch, dcs_pkg::VEC_DONE);
          end
        end
      end
      default: if (m_pend[ch]) begin
        m_mar[ch] = q.desc_address;
        m_mtc[ch] = q.desc_count;
        m_pend[ch] = 0;
      end
    endcase
    if (step_out.size() > 0) step_out[step_out.size()-1].last = 1;
    foreach (step_out[i]) expected_results.push_back(step_out[i]);
  endtask

  function automatic dcs_pkg::req_t mk(input logic [1:0] m, input int ch,
                                       input logic [4:0] idx, input logic [15:0] d);
    dcs_pkg::req_t q;
    q = '0;
    q.mode = m;
    q.channel = ch[1:0];
    q.reg_index = idx;
    q.write_data = d;
    q.upper_enable = 1;
    q.lower_enable = 1;
    return q;
  endfunction

  function automatic dcs_pkg::req_t rand_req();
    logic [95:0] raw;
    dcs_pkg::req_t q;
    raw = {$urandom, $urandom, $urandom};
    q = raw[$bits(dcs_pkg::req_t)-1:0];
    return q;
  endfunction

  function automatic dcs_pkg::req_t reply(input int ch);
    dcs_pkg::req_t q;
    q = rand_req();
    q.mode = dcs_pkg::MODE_REPLY;
    q.channel = ch[1:0];
    q.desc_count = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    return q;
  endfunction

  // one transfer program on a channel with random content, with some fully random requests mixed in
  task automatic add_program(input int ch);
    logic [7:0] opc;
    int n;
    opc = 8'($urandom);
    if ($urandom_range(0, 2) == 0) opc[3:2] = 2'b00;
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, ch, dcs_pkg::R_DOCTL,
                              {8'($urandom), opc}));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, ch, dcs_pkg::R_SCCTL,
                              {8'($urandom), 8'h00}));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, ch, dcs_pkg::R_MTC,
                              16'($urandom_range(0, 4))));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, ch,
                              $urandom_range(0, 1) ? dcs_pkg::R_MARL : dcs_pkg::R_MARH,
                              16'($urandom)));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, ch,
                              $urandom_range(0, 1) ? dcs_pkg::R_DARL : dcs_pkg::R_DARH,
                              16'($urandom)));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, ch, dcs_pkg::R_BTC,
                              16'($urandom_range(0, 2))));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, ch,
                              $urandom_range(0, 1) ? dcs_pkg::R_BARL : dcs_pkg::R_BARH,
                              16'($urandom)));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, ch, dcs_pkg::R_SCCTL,
                              {8'($urandom), 1'b1, 2'($urandom), $urandom_range(0, 5) == 0,
                               4'($urandom)}));
    n = $urandom_range(2, 10);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: pending_reqs.push_back(mk(dcs_pkg::MODE_TICK, ch, 5'd0, 16'd0));
        5, 6: pending_reqs.push_back(reply(ch));
        7: pending_reqs.push_back(mk(dcs_pkg::MODE_READ, ch, 5'($urandom), 16'd0));
        8: pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, ch, dcs_pkg::R_SCCTL,
                                     {8'($urandom), 8'h10}));
        default: pending_reqs.push_back(rand_req());
      endcase
    end
  endtask

  task automatic fill_directed();
    for (int ch = 0; ch < 4; ch++) begin
      pending_reqs.push_back(mk(dcs_pkg::MODE_READ, ch, dcs_pkg::R_NIV, 16'd0));
    end
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 0, dcs_pkg::R_MARH, 16'hffff));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 0, dcs_pkg::R_MARL, 16'hfffe));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 0, dcs_pkg::R_SCCTL, 16'h0400));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 0, dcs_pkg::R_DOCTL, 16'hff20));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 0, dcs_pkg::R_SCCTL, 16'h0580));
    pending_reqs.push_back(mk(dcs_pkg::MODE_TICK, 0, 5'd0, 16'd0));
    pending_reqs.push_back(mk(dcs_pkg::MODE_READ, 0, dcs_pkg::R_MARL, 16'd0));
    pending_reqs.push_back(mk(dcs_pkg::MODE_READ, 0, dcs_pkg::R_STATUS, 16'd0));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 0, dcs_pkg::R_STATUS, 16'hffff));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 1, dcs_pkg::R_DOCTL, 16'h0034));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 1, dcs_pkg::R_BTC, 16'hffff));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 1, dcs_pkg::R_SCCTL, 16'hff90));
    pending_reqs.push_back(mk(dcs_pkg::MODE_READ, 1, dcs_pkg::R_STATUS, 16'd0));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 1, dcs_pkg::R_SCCTL, 16'h0080));
    pending_reqs.push_back(mk(dcs_pkg::MODE_TICK, 1, 5'd0, 16'd0));
    pending_reqs.push_back(reply(1));
    pending_reqs.push_back(mk(dcs_pkg::MODE_TICK, 1, 5'd0, 16'd0));
    pending_reqs.push_back(mk(dcs_pkg::MODE_READ, 2, 5'h1e, 16'd0));
    pending_reqs.push_back(mk(dcs_pkg::MODE_WRITE, 3, dcs_pkg::R_BFC, 16'hffff));
    pending_reqs.push_back(mk(dcs_pkg::MODE_READ, 3, dcs_pkg::R_BFC, 16'd0));
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
      in_data <= '0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_request(in_data);
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= sender_idle) begin
        in_valid <= 1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", out_data, '0);
        end else if (out_data !== expected_results[0]) begin
          report("result", out_data, expected_results[0]);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
      out_stall <= hold_off || ($urandom_range(0, 99) < receiver_idle);
    end
  end

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((pending_reqs.size() > 0 || in_valid || expected_results.size() > 0) &&
           guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int k;
    k = 0;
    while (k < count) begin
      if ($urandom_range(0, 4) != 0) begin
        add_program($urandom_range(0, 3));
        k += 14;
      end else begin
        pending_reqs.push_back(rand_req());
        k++;
      end
    end
  endtask

  initial begin
    rst_n = 0;
    for (int ch = 0; ch < 4; ch++) begin
      m_status[ch] = 0; m_error[ch] = 0; m_devc[ch] = 0; m_opc[ch] = 0;
      m_seqc[ch] = 0; m_chc[ch] = 0; m_mtc[ch] = 0; m_btc[ch] = 0;
      m_mar[ch] = 0; m_dar[ch] = 0; m_bar[ch] = 0; m_fcpg[ch] = 0;
      m_niv[ch] = 8'h0f; m_eiv[ch] = 8'h0f; m_gcr[ch] = 0; m_pend[ch] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1;
    fill_directed();
    wait_drained();
    sender_idle = 0; receiver_idle = 0;
    random_phase(300);
    // long receiver hold-off while requests keep coming
    hold_off = 1;
    repeat (300) @(posedge clk);
    hold_off = 0;
    wait_drained();
    sender_idle = 84; receiver_idle = 0;
    random_phase(300);
    wait_drained();
    sender_idle = 0; receiver_idle = 84;
    random_phase(300);
    wait_drained();
    sender_idle = 26; receiver_idle = 26;
    random_phase(330);
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
